/* sv/rfb_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the radio frame builder.
package rfb_pkg;

  localparam logic [7:0]  PREAMBLE_HI = 8'hAA;
  localparam logic [7:0]  PREAMBLE_LO = 8'h55;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_MSB     = 16'h8000;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t REG_LENGTH = 1'd0;
  localparam cfg_index_t REG_SKIP   = 1'd1;

  // Position of a beat within the sequence that one item can cause
  typedef logic [2:0] beat_idx_t;

  localparam beat_idx_t BEAT_PRE0   = 3'd0;
  localparam beat_idx_t BEAT_PRE1   = 3'd1;
  localparam beat_idx_t BEAT_PRE2   = 3'd2;
  localparam beat_idx_t BEAT_PRE3   = 3'd3;
  localparam beat_idx_t BEAT_LENGTH = 3'd4;
  localparam beat_idx_t BEAT_DATA   = 3'd5;
  localparam beat_idx_t BEAT_CRC_HI = 3'd6;
  localparam beat_idx_t BEAT_CRC_LO = 3'd7;

  // What the CRC tracker reports for the item being accepted
  typedef struct packed {
    logic        first;
    logic        closes;
    logic [15:0] crc;
  } crc_info_t;

  // CRC-16, MSB first, one byte folded in over eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/radio_frame_builder_crc16_core.sv */
// Radio frame builder: preamble, length, pass-through bytes and trailing CRC-16.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  data_byte, final_byte
//   out      out_valid/ out_stall out_byte, run_last, frame_end
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A byte's CRC is folded in at the edge that takes it; the item is held in a
// record register that feeds the output register a beat a cycle unless stalled.
// An opening byte gives six beats, a final byte three, any other byte one; the
// input is taken every cycle only while items are one beat and out_stall is low.
// The next item is taken on the edge that moves the last beat of the current one.
// Reset clears the CRC, the position, the record and the output register, and
// holds off input and configuration beats while it is high.
// A stalled output holds its beat; the record then waits and the input stalls.
module radio_frame_builder_crc16_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            final_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            run_last,
  output logic                            frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  rfb_pkg::cfg_index_t             cfg_index,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]         length_value;
  logic [1:0]         crc_skip;
  logic               accept;
  rfb_pkg::crc_info_t info;

  logic               rec_valid;
  rfb_pkg::beat_idx_t rec_idx;
  logic               rec_fin;
  logic [7:0]         rec_byte;
  logic [15:0]        rec_crc;

  logic               load;
  logic               rec_last;
  logic [7:0]         beat_byte;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_value <= 8'd57;
      crc_skip     <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfb_pkg::REG_LENGTH: length_value <= cfg_data[7:0];
        rfb_pkg::REG_SKIP:   crc_skip     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  rfb_crc_track u_crc (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .crc_skip   (crc_skip),
    .info       (info)
  );

  assign load     = rec_valid && (!out_valid || !out_stall);
  assign rec_last = rec_fin ? (rec_idx == rfb_pkg::BEAT_CRC_LO)
                            : (rec_idx == rfb_pkg::BEAT_DATA);
  assign in_stall = rst || (rec_valid && !(load && rec_last));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (rec_idx)
      rfb_pkg::BEAT_PRE0:   beat_byte = rfb_pkg::PREAMBLE_HI;
      rfb_pkg::BEAT_PRE1:   beat_byte = rfb_pkg::PREAMBLE_HI;
      rfb_pkg::BEAT_PRE2:   beat_byte = rfb_pkg::PREAMBLE_LO;
      rfb_pkg::BEAT_PRE3:   beat_byte = rfb_pkg::PREAMBLE_LO;
      rfb_pkg::BEAT_LENGTH: beat_byte = length_value;
      rfb_pkg::BEAT_DATA:   beat_byte = rec_byte;
      rfb_pkg::BEAT_CRC_HI: beat_byte = rec_crc[15:8];
      rfb_pkg::BEAT_CRC_LO: beat_byte = rec_crc[7:0];
      default:              beat_byte = rec_byte;
    endcase
  end

  // item record
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      rec_idx   <= rfb_pkg::BEAT_DATA;
    end else begin
      if (accept) begin
        rec_valid <= 1'b1;
        rec_idx   <= info.first ? rfb_pkg::BEAT_PRE0 : rfb_pkg::BEAT_DATA;
      end else if (load) begin
        if (rec_last) begin
          rec_valid <= 1'b0;
        end else begin
          rec_idx <= rec_idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_fin  <= info.closes;
      rec_byte <= data_byte;
      rec_crc  <= info.crc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= beat_byte;
      run_last  <= rec_last;
      frame_end <= (rec_idx == rfb_pkg::BEAT_CRC_LO);
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("frame end beat not marked as last of its item");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> rec_valid)
    else $error("accepted item did not reach the record");

  a_record_holds: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !load |=> rec_valid && $stable(rec_idx))
    else $error("record advanced without a beat moving");

  a_crc_lo_final: assert property (@(posedge clk) disable iff (rst)
    load && (rec_idx == rfb_pkg::BEAT_CRC_LO) |-> rec_fin)
    else $error("CRC beat emitted for a non-final item");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_last |-> !accept)
    else $error("item accepted while record still has beats");

endmodule

/* sv/rfb_crc_track.sv */
// Running CRC and packet position; reports the CRC after the accepted byte.
module rfb_crc_track (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               final_byte,
  input  logic [1:0]         crc_skip,
  output rfb_pkg::crc_info_t info
);

  logic [15:0] crc_reg;
  logic [15:0] crc_reg_next;
  logic [1:0]  bytes_seen;
  logic [1:0]  bytes_seen_next;
  logic [15:0] crc_after;
  logic        first;
  logic        closes;

  assign first  = (bytes_seen == 2'd0);
  // a final flag on the opening byte is dropped: the packet carries on
  assign closes = final_byte && !first;

  assign crc_after = (bytes_seen >= crc_skip) ? rfb_pkg::crc_byte(crc_reg, data_byte)
                                              : crc_reg;

  always_comb begin
    crc_reg_next    = crc_reg;
    bytes_seen_next = bytes_seen;
    if (accept) begin
      if (closes) begin
        crc_reg_next    = 16'h0000;
        bytes_seen_next = 2'd0;
      end else begin
        crc_reg_next = crc_after;
        if (bytes_seen != 2'd3) begin
          bytes_seen_next = bytes_seen + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= 16'h0000;
      bytes_seen <= 2'd0;
    end else begin
      crc_reg    <= crc_reg_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  assign info.first  = first;
  assign info.closes = closes;
  assign info.crc    = crc_after;

endmodule

/* verif/radio_frame_builder_crc16_core_test.sv */
// Self-checking testbench for the radio frame builder core with CRC-16 trailer.
module radio_frame_builder_crc16_core_test;

  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 146;

  typedef struct {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } wire_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  rfb_pkg::cfg_index_t cfg_index = rfb_pkg::REG_LENGTH;
  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the framer state
  logic [7:0]  length_byte = 8'd57;
  logic [1:0]  skip_count  = 2'd1;
  logic [15:0] frame_crc   = 16'h0000;
  logic [1:0]  packet_pos  = 2'd0;

  wire_beat_t wire_beats_due[$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 11;
  int         recv_stall_pct = 56;

  radio_frame_builder_crc16_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Bitwise CRC-16, feedback taken from the top bit against each data bit
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic        feedback;
    logic [15:0] acc;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (feedback) begin
        acc = acc ^ rfb_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void push_beat(input logic [7:0] v, input logic last, input logic fin);
    wire_beat_t beat;
    beat.value     = v;
    beat.run_last  = last;
    beat.frame_end = fin;
    wire_beats_due.push_back(beat);
  endfunction

  function automatic void predict_frame_beats(input logic [7:0] b, input logic fin);
    logic opening;
    opening = (packet_pos == 2'd0);
    if (opening) begin
      push_beat(rfb_pkg::PREAMBLE_HI, 1'b0, 1'b0);
      push_beat(rfb_pkg::PREAMBLE_HI, 1'b0, 1'b0);
      push_beat(rfb_pkg::PREAMBLE_LO, 1'b0, 1'b0);
      push_beat(rfb_pkg::PREAMBLE_LO, 1'b0, 1'b0);
      push_beat(length_byte, 1'b0, 1'b0);
    end
    if (packet_pos >= skip_count) begin
      frame_crc = crc16_fold(frame_crc, b);
    end
    if (packet_pos != 2'd3) begin
      packet_pos = packet_pos + 2'd1;
    end
    // a final flag on the opening byte is dropped
    if (fin && !opening) begin
      push_beat(b, 1'b0, 1'b0);
      push_beat(frame_crc[15:8], 1'b0, 1'b0);
      push_beat(frame_crc[7:0], 1'b1, 1'b1);
      frame_crc  = 16'h0000;
      packet_pos = 2'd0;
    end else begin
      push_beat(b, 1'b1, 1'b0);
    end
  endfunction

  always @(posedge clk) begin
    wire_beat_t due;
    if (!rst && out_valid && !out_stall) begin
      if (wire_beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %02h", out_byte));
      end else begin
        due = wire_beats_due.pop_front();
        if (out_byte !== due.value) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, due.value));
        end
        if (run_last !== due.run_last) begin
          report_mismatch($sformatf("run_last %b, want %b", run_last, due.run_last));
        end
        if (frame_end !== due.frame_end) begin
          report_mismatch($sformatf("frame_end %b, want %b", frame_end, due.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold the beat until it is taken; idle beforehand at random
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    predict_frame_beats(b, fin);
  endtask

  // Drop valid and wait for every outstanding beat
  task automatic drain_frames();
    in_valid <= 1'b0;
    do @(posedge clk); while (wire_beats_due.size() != 0);
  endtask

  task automatic write_reg(input rfb_pkg::cfg_index_t idx,
                           input logic [rfb_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rfb_pkg::REG_LENGTH) begin
      length_byte = value;
    end else if (idx == rfb_pkg::REG_SKIP) begin
      skip_count = value[1:0];
    end
  endtask

  task automatic set_framing(input logic [7:0] len, input logic [7:0] skip_raw);
    write_reg(rfb_pkg::REG_LENGTH, len);
    write_reg(rfb_pkg::REG_SKIP, skip_raw);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain_frames();
  endtask

  task automatic test_final_on_opening_byte();
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b1);
    drain_frames();
  endtask

  task automatic test_skip_covers_packet();
    set_framing(8'h00, 8'h03);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    // bytes past the third all enter the CRC
    for (int k = 0; k < 5; k++) begin
      send_byte(8'h80 + 8'(k * 17), k == 4);
    end
    drain_frames();
  endtask

  task automatic test_crc_every_byte();
    set_framing(8'hFF, 8'h00);
    for (int k = 0; k < 9; k++) begin
      send_byte(8'h31 + 8'(k), k == 8);
    end
    drain_frames();
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    int         sent;
    int         plen;
    logic [7:0] b;
    logic       fin;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0:       plen = $urandom_range(7, 24);
        1, 2, 3: plen = 2;
        default: plen = $urandom_range(3, 6);
      endcase
      for (int k = 0; k < plen; k++) begin
        b   = 8'($urandom_range(255));
        fin = (k == plen - 1);
        // stray final flag on the opening byte, which the framer drops
        if (k == 0 && $urandom_range(7) == 0) begin
          fin = 1'b1;
        end
        send_byte(b, fin);
        sent++;
      end
    end
    drain_frames();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_final_on_opening_byte();
    test_skip_covers_packet();
    test_crc_every_byte();
    set_framing(8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(RANDOM_ITEMS, 11, 56);
    set_framing(8'h00, 8'hFE);
    test_random_traffic(RANDOM_ITEMS, 56, 11);
    set_framing(8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && wire_beats_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rfb_pkg.sv
sv/rfb_crc_track.sv
sv/radio_frame_builder_crc16_core.sv
verif/radio_frame_builder_crc16_core_test.sv
